FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

FILE: rtl/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Widths and shared types of the circle collision response pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

  // magnitude of the dot-scaled offset, |d| * |rv.d|
  localparam int NUM_W = 99;
  // squared distance
  localparam int DEN_W = 66;
  // quotient bits produced; anything larger saturates the velocity anyway
  localparam int QBITS = 35;
  // register stages through the divider
  localparam int DIV_LAT = QBITS + 2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sd1;

  // item context carried alongside the divider
  typedef struct packed {
    logic               hit;
    logic               apply;
    logic               coinc;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
    logic signed [31:0] nbpy;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/circle_collision_response_top.sv
// ----------------------------------------------------------------------------
// circle_collision_response_top
// Elastic equal-mass collision response for one candidate pair of particles.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata: positions, velocities, diameters; tuser: kinds
//  m_axis    out  tdata: new velocities, new B y; tuser: overlap, impulse
//
//  One pair is taken every cycle while m_axis does not stall; results pass through
//  the pipeline stages, the one-bit-per-stage divider and an output register.
//  Reset clears only the valid bits of the pipeline.
//  A stall on m_axis freezes the whole pipeline and drops s_axis_tready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_collision_response_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_diameter,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_diameter, zero pad
  input  wire logic [319:0] s_axis_tdata_i,
  // a_kind, b_kind
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y, new_b_pos_y
  output logic [159:0]      m_axis_tdata_o,
  // overlap, impulse_applied
  output logic [1:0]        m_axis_tuser_o
);

  localparam int NUDGE_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int NUDGE     = (NUDGE_RAW > 0) ? NUDGE_RAW : 1;
  localparam int NW        = ccr_pkg::NUM_W;
  localparam int DN        = ccr_pkg::DEN_W;
  localparam int QB        = ccr_pkg::QBITS;
  localparam int DL        = ccr_pkg::DIV_LAT;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'(ccr_pkg::S32_MAX)) r = ccr_pkg::S32_MAX;
    else if (v < 38'(ccr_pkg::S32_MIN)) r = ccr_pkg::S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  logic adv;
  logic out_vld_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---- input fields
  logic signed [31:0] ax, ay, avx, avy, bx, by, bvx, bvy;
  logic        [30:0] ad, bd;

  always_comb begin
    ax  = s_axis_tdata_i[31:0];
    ay  = s_axis_tdata_i[63:32];
    avx = s_axis_tdata_i[95:64];
    avy = s_axis_tdata_i[127:96];
    ad  = s_axis_tdata_i[158:128];
    bx  = s_axis_tdata_i[190:159];
    by  = s_axis_tdata_i[222:191];
    bvx = s_axis_tdata_i[254:223];
    bvy = s_axis_tdata_i[286:255];
    bd  = s_axis_tdata_i[317:287];
  end

  // ---- stage 1: differences
  logic               v1_q;
  logic signed [32:0] dx_q1, dy_q1, rvx_q1, rvy_q1;
  logic        [31:0] sumd_q1;
  logic               ball_q1, coinc_q1;
  logic signed [31:0] avx_q1, avy_q1, bvx_q1, bvy_q1, by_q1, byn_q1;
  logic signed [32:0] byn_sum;

  assign byn_sum = {by[31], by} + 33'(NUDGE);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q1    <= {bx[31], bx} - {ax[31], ax};
      dy_q1    <= {by[31], by} - {ay[31], ay};
      rvx_q1   <= {bvx[31], bvx} - {avx[31], avx};
      rvy_q1   <= {bvy[31], bvy} - {avy[31], avy};
      sumd_q1  <= {1'b0, ad} + {1'b0, bd};
      ball_q1  <= !s_axis_tuser_i[0] && !s_axis_tuser_i[1];
      coinc_q1 <= (ax == bx) && (ay == by);
      avx_q1   <= avx;
      avy_q1   <= avy;
      bvx_q1   <= bvx;
      bvy_q1   <= bvy;
      by_q1    <= by;
      // clamp the nudge at the top of the range
      byn_q1   <= (byn_sum[32] != byn_sum[31]) ? ccr_pkg::S32_MAX : byn_sum[31:0];
    end
  end

  // ---- stage 2: products
  logic               v2_q;
  logic        [65:0] dx2_q2, dy2_q2;
  logic        [63:0] reach_q2;
  logic signed [65:0] px_q2, py_q2;
  logic signed [32:0] dx_q2, dy_q2;
  logic               rvy_le0_q2, ball_q2, coinc_q2;
  logic signed [31:0] avx_q2, avy_q2, bvx_q2, bvy_q2, by_q2, byn_q2;
  logic signed [65:0] dx2_s, dy2_s, px_s, py_s;

  always_comb begin
    dx2_s = dx_q1 * dx_q1;
    dy2_s = dy_q1 * dy_q1;
    px_s  = dx_q1 * rvx_q1;
    py_s  = dy_q1 * rvy_q1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx2_q2     <= dx2_s;
      dy2_q2     <= dy2_s;
      reach_q2   <= sumd_q1 * sumd_q1;
      px_q2      <= px_s;
      py_q2      <= py_s;
      dx_q2      <= dx_q1;
      dy_q2      <= dy_q1;
      rvy_le0_q2 <= rvy_q1[32] || (rvy_q1 == '0);
      ball_q2    <= ball_q1;
      coinc_q2   <= coinc_q1;
      avx_q2     <= avx_q1;
      avy_q2     <= avy_q1;
      bvx_q2     <= bvx_q1;
      bvy_q2     <= bvy_q1;
      by_q2      <= by_q1;
      byn_q2     <= byn_q1;
    end
  end

  // ---- stage 3: distance, overlap test, normal velocity
  logic               v3_q;
  logic        [65:0] dist2_q3;
  logic signed [66:0] dot_q3;
  logic signed [32:0] dx_q3, dy_q3;
  logic               hit_q3, rvy_le0_q3, coinc_q3;
  logic signed [31:0] avx_q3, avy_q3, bvx_q3, bvy_q3, nbpy_q3;
  logic        [65:0] dist2_s;
  logic               hit_s;

  always_comb begin
    dist2_s = dx2_q2 + dy2_q2;
    hit_s   = ball_q2 && ({dist2_s, 2'b00} <= {4'b0000, reach_q2});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist2_q3   <= dist2_s;
      hit_q3     <= hit_s;
      dot_q3     <= {px_q2[65], px_q2} + {py_q2[65], py_q2};
      dx_q3      <= dx_q2;
      dy_q3      <= dy_q2;
      rvy_le0_q3 <= rvy_le0_q2;
      coinc_q3   <= coinc_q2;
      avx_q3     <= avx_q2;
      avy_q3     <= avy_q2;
      bvx_q3     <= bvx_q2;
      bvy_q3     <= bvy_q2;
      nbpy_q3    <= (hit_s && coinc_q2) ? byn_q2 : by_q2;
    end
  end

  // ---- stage 4: decision and partial products of d * |dot|
  logic               v4_q;
  logic        [65:0] plx_q4, phx_q4, ply_q4, phy_q4;
  logic        [65:0] dist2_q4;
  ccr_pkg::side_t     side_q4;
  logic        [66:0] mdot_w;
  logic        [65:0] mdot;
  logic        [32:0] mdx, mdy;
  logic               dot_le0;

  always_comb begin
    mdot_w  = dot_q3[66] ? 67'(-dot_q3) : 67'(dot_q3);
    mdot    = mdot_w[65:0];
    mdx     = dx_q3[32] ? 33'(-dx_q3) : 33'(dx_q3);
    mdy     = dy_q3[32] ? 33'(-dy_q3) : 33'(dy_q3);
    dot_le0 = dot_q3[66] || (dot_q3 == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plx_q4        <= mdx * mdot[32:0];
      phx_q4        <= mdx * mdot[65:33];
      ply_q4        <= mdy * mdot[32:0];
      phy_q4        <= mdy * mdot[65:33];
      dist2_q4      <= dist2_q3;
      side_q4.hit   <= hit_q3;
      side_q4.apply <= hit_q3 && (coinc_q3 ? rvy_le0_q3 : dot_le0);
      side_q4.coinc <= coinc_q3;
      side_q4.neg_x <= dx_q3[32] ^ dot_q3[66];
      side_q4.neg_y <= dy_q3[32] ^ dot_q3[66];
      side_q4.avx   <= avx_q3;
      side_q4.avy   <= avy_q3;
      side_q4.bvx   <= bvx_q3;
      side_q4.bvy   <= bvy_q3;
      side_q4.nbpy  <= nbpy_q3;
    end
  end

  // ---- stage 5: combine partial products
  logic            v5_q;
  logic [NW-1:0]   numx_q5, numy_q5;
  logic [DN-1:0]   den_q5;
  ccr_pkg::side_t  side_q5;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q5 <= NW'(plx_q4) + {phx_q4, 33'd0};
      numy_q5 <= NW'(ply_q4) + {phy_q4, 33'd0};
      den_q5  <= dist2_q4;
      side_q5 <= side_q4;
    end
  end

  // ---- divider, side data delayed alongside
  logic [QB-1:0]  qx, qy;
  logic           ovfx, ovfy;
  logic [DL-1:0]  vd_q;
  ccr_pkg::side_t sd_q [0:DL-1];

  ccr_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx_q5),
    .den_i (den_q5),
    .quo_o (qx),
    .ovf_o (ovfx)
  );

  ccr_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy_q5),
    .den_i (den_q5),
    .quo_o (qy),
    .ovf_o (ovfy)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side_q5;
      for (int k = 1; k < DL; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // ---- final: apply impulse and saturate
  ccr_pkg::side_t     sf;
  logic        [QB:0] magx, magy;
  logic signed [36:0] ex, ey;
  logic signed [31:0] nax, nay, nbx, nby;

  always_comb begin
    sf   = sd_q[DL-1];
    magx = ovfx ? (QB+1)'(1) << QB : {1'b0, qx};
    magy = ovfy ? (QB+1)'(1) << QB : {1'b0, qy};
    ex   = sf.neg_x ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    ey   = sf.neg_y ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    nax  = sf.avx;
    nay  = sf.avy;
    nbx  = sf.bvx;
    nby  = sf.bvy;
    if (sf.apply) begin
      if (sf.coinc) begin
        // normal is straight up: swap the y velocities
        nay = sf.bvy;
        nby = sf.avy;
      end else begin
        nax = sat32(38'(sf.avx) + 38'(ex));
        nay = sat32(38'(sf.avy) + 38'(ey));
        nbx = sat32(38'(sf.bvx) - 38'(ex));
        nby = sat32(38'(sf.bvy) - 38'(ey));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata_o <= {sf.nbpy, nby, nbx, nay, nax};
      m_axis_tuser_o <= {sf.apply, sf.hit};
    end
  end

  // ---- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      vd_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      vd_q      <= {vd_q[DL-2:0], v5_q};
      out_vld_q <= vd_q[DL-1];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;

  // ---- checks
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_impulse_needs_hit, out_vld_q && m_axis_tuser_o[1] && !m_axis_tuser_o[0], "impulse without overlap")
  `ASSERT_PROP(a_stall_blocks_input, out_vld_q && !m_axis_tready_i |-> !s_axis_tready_o, "input taken during stall")
  `ASSERT_PROP(a_accept_enters, s_axis_tvalid_i && s_axis_tready_o |=> v1_q, "accepted request lost at entry")

endmodule

`default_nettype wire

FILE: rtl/ccr_div.sv
// ----------------------------------------------------------------------------
// ccr_div
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest (ties away from zero) and an overflow flag for large quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_div (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [ccr_pkg::NUM_W-1:0]    num_i,
  input  wire logic [ccr_pkg::DEN_W-1:0]    den_i,
  output logic      [ccr_pkg::QBITS-1:0]    quo_o,
  output logic                              ovf_o
);

  localparam int NW = ccr_pkg::NUM_W + 1;  // 2*num + den
  localparam int DW = ccr_pkg::DEN_W + 1;  // 2*den
  localparam int QB = ccr_pkg::QBITS;

  logic [NW-1:0] n_q;
  logic [DW-1:0] d0_q;

  logic [DW-1:0] rem_q [0:QB];
  logic [DW-1:0] d_q   [0:QB];
  logic [QB-1:0] low_q [0:QB];
  logic [QB-1:0] quo_q [0:QB];
  logic          ovf_q [0:QB];

  logic [DW-1:0] head;
  logic          ovf;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= {num_i, 1'b0} + NW'(den_i);
      d0_q <= {den_i, 1'b0};
    end
  end

  always_comb begin
    head = DW'(n_q[NW-1:QB]);
    ovf  = head >= d0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= head;
      d_q[0]   <= d0_q;
      low_q[0] <= n_q[QB-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][QB-1]};
      ge    = trial >= {1'b0, d_q[k-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, d_q[k-1]}) : trial[DW-1:0];
        d_q[k]   <= d_q[k-1];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QB-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

`default_nettype wire

FILE: tb/ccr_checker.sv
// ----------------------------------------------------------------------------
// ccr_checker
// Watches both streams of the collision response block, predicts each
// result from the accepted pair and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [319:0] s_axis_tdata_i,
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [159:0] m_axis_tdata_i,
  input  wire logic [1:0]   m_axis_tuser_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam longint NUDGE_LSB = 66;

  typedef struct packed {
    logic [1:0]   flags;
    logic [159:0] vels;
  } response_t;

  // expected results in request order
  response_t  exp_mem [0:4095];
  logic [11:0] wr_ptr_q, rd_ptr_q;

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round(|dc*dot|/den), ties away from zero, negative when dc and dot differ in sign; capped at 2^40
  function automatic logic signed [63:0] scaled_share(logic signed [63:0] dc,
      logic signed [127:0] dot, logic [127:0] den);
    logic [127:0] num, q;
    logic         neg;
    num = (dc < 0 ? -dc : dc) * (dot < 0 ? -dot : dot);
    neg = (dc < 0) != (dot < 0);
    q = (2 * num + den) / (2 * den);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic response_t collide(logic [319:0] d, logic [1:0] u);
    logic signed [63:0] ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, rvx, rvy;
    logic signed [63:0] nax, nay, nbx, nby, nbpy, ex, ey;
    logic [63:0]        ad, bd;
    logic [127:0]       dist2, reach;
    logic signed [127:0] dot;
    logic               hit, applied;
    response_t          r;
    ax = $signed(d[31:0]);    ay = $signed(d[63:32]);
    avx = $signed(d[95:64]);  avy = $signed(d[127:96]);
    ad = d[158:128];
    bx = $signed(d[190:159]); by = $signed(d[222:191]);
    bvx = $signed(d[254:223]); bvy = $signed(d[286:255]);
    bd = d[317:287];
    nax = avx; nay = avy; nbx = bvx; nby = bvy; nbpy = by;
    dx = bx - ax; dy = by - ay; rvx = bvx - avx; rvy = bvy - avy;
    hit = 0; applied = 0;
    if (u == 2'b00) begin
      dist2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      reach = (ad + bd) * (ad + bd);
      hit = 4 * dist2 <= reach;
      if (hit) begin
        if (dx == 0 && dy == 0) begin
          nbpy = clamp32(by + NUDGE_LSB);
          if (rvy <= 0) begin
            applied = 1; nay = bvy; nby = avy;
          end
        end else begin
          dot = 128'(dx) * 128'(rvx) + 128'(dy) * 128'(rvy);
          if (dot <= 0) begin
            ex = scaled_share(dx, dot, dist2);
            ey = scaled_share(dy, dot, dist2);
            applied = 1;
            nax = clamp32(avx + ex); nay = clamp32(avy + ey);
            nbx = clamp32(bvx - ex); nby = clamp32(bvy - ey);
          end
        end
      end
    end
    r.flags = {applied, hit};
    r.vels = {nbpy[31:0], nby[31:0], nbx[31:0], nay[31:0], nax[31:0]};
    return r;
  endfunction

  assign pending_o = int'(12'(wr_ptr_q - rd_ptr_q));

  always @(posedge clk_i) begin
    response_t want;
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        exp_mem[wr_ptr_q] <= collide(s_axis_tdata_i, s_axis_tuser_i);
        wr_ptr_q          <= wr_ptr_q + 12'd1;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (wr_ptr_q == rd_ptr_q) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", m_axis_tdata_i);
        end else begin
          want     = exp_mem[rd_ptr_q];
          rd_ptr_q <= rd_ptr_q + 12'd1;
          if (want.flags !== m_axis_tuser_i || want.vels !== m_axis_tdata_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: exp user %b data %h, got user %b data %h",
                       want.flags, want.vels, m_axis_tuser_i, m_axis_tdata_i);
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random particle pairs into the collision response
// block with random gaps and back-pressure, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int N_RANDOM = 1900;
  localparam int WATCHDOG = 20000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [319:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [159:0] m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count, pending, idle_cycles;
  logic         hold_rx = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  circle_collision_response_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  ccr_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  function automatic logic [31:0] pick32(int mode);
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return mode == 0 ? $urandom_range(32'h0004_0000) - 32'h0002_0000
                                : $urandom_range(32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // positions near each other so that most pairs overlap
  function automatic logic [319:0] make_pair(output logic [1:0] kinds);
    logic [31:0] ax, ay, bx, by;
    logic [30:0] ad, bd;
    ax = pick32(0); ay = pick32(0);
    bx = ax + ($urandom_range(32'h0002_0000) - 32'h0001_0000);
    by = ay + ($urandom_range(32'h0002_0000) - 32'h0001_0000);
    if ($urandom_range(9) == 0) begin bx = ax; by = ay; end
    if ($urandom_range(19) == 0) begin bx = $urandom(); by = $urandom(); end
    ad = $urandom_range(9) == 0 ? $urandom() : $urandom_range(32'h0003_0000);
    bd = $urandom_range(9) == 0 ? $urandom() : $urandom_range(32'h0003_0000);
    kinds = $urandom_range(4) == 0 ? 2'($urandom()) : 2'b00;
    return {2'b00, bd, pick32(1), pick32(1), by, bx, ad, pick32(1), pick32(1), ay, ax};
  endfunction

  // hold valid across back-to-back requests; drop it only for a gap
  task automatic send(logic [319:0] d, logic [1:0] k);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1; s_tdata <= d; s_tuser <= k;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (hold_rx) m_tready <= 0;
    else m_tready <= $urandom_range(9) < 7 || $urandom_range(3) == 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [1:0]   k;
    logic [319:0] d;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // extremes, coincident centres, kinds, saturation
    send('0, 2'b00);
    send({2'b00, 31'h7FFF_FFFF, {4{32'h7FFF_FFFF}}, 31'h7FFF_FFFF,
          {4{32'h8000_0000}}}, 2'b00);
    send({2'b00, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, {2{32'h7FFF_FFFF}},
          31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, {2{32'h7FFF_FFFF}}}, 2'b00);
    send({2'b00, 31'h1_0000, 32'h0, 32'hFFFF_0000, 32'h7FFF_FFF0, 32'h0,
          31'h1_0000, 32'h0, 32'h0001_0000, 32'h7FFF_FFF0, 32'h0}, 2'b00);
    send({2'b00, 31'h2_0000, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000,
          31'h2_0000, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0}, 2'b00);
    send({2'b00, 31'h2_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000,
          31'h2_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 2'b00);
    for (int i = 0; i < 4; i++) send({2'b00, 31'h2_0000, 32'h0, 32'h1, 32'h0, 32'h0,
          31'h2_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 2'(i));
    for (int i = 0; i < 12; i++) begin
      d = make_pair(k);
      send(d, k);
    end
    s_tvalid <= 0;
    // drain before the random part
    hold_rx <= 1;
    repeat (60) @(posedge clk_i);
    hold_rx <= 0;
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < N_RANDOM; i++) begin
      d = make_pair(k);
      send(d, k);
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
